@@ rtl/i2a_pkg.sv @@
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int WordBits      = 32;
  localparam int DigitCount    = 10;
  localparam int BcdBits       = 4 * DigitCount;
  localparam int StepsPerStage = 4;
  localparam int StageCount    = WordBits / StepsPerStage;
  localparam int CharBits      = 7;
  localparam int IndexBits     = 4;

  localparam logic CMD_DEC = 1'b0;
  localparam logic CMD_HEX = 1'b1;

  localparam logic [CharBits-1:0] CH_ZERO    = 7'h30;
  localparam logic [CharBits-1:0] CH_LOWER_A = 7'h61;
  localparam logic [CharBits-1:0] CH_MINUS   = 7'h2d;

  // word being converted: bin shifts out msb first into the digit register
  typedef struct packed {
    logic                hex;
    logic                neg;
    logic [WordBits-1:0] bin;
    logic [BcdBits-1:0]  bcd;
  } conv_t;

  // one double-dabble step; hex mode skips the add-3 so nibbles stay binary
  function automatic conv_t dabble_step(conv_t c);
    conv_t      r;
    logic [3:0] dg;
    r = c;
    for (int i = 0; i < DigitCount; i++) begin
      dg = r.bcd[4*i +: 4];
      if (!r.hex && dg >= 4'd5) begin
        r.bcd[4*i +: 4] = dg + 4'd3;
      end
    end
    r.bcd = {r.bcd[BcdBits-2:0], r.bin[WordBits-1]};
    r.bin = {r.bin[WordBits-2:0], 1'b0};
    return r;
  endfunction

  function automatic logic [CharBits-1:0] digit_char(logic [3:0] d);
    logic [CharBits-1:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {3'b000, d};
    end else begin
      r = CH_LOWER_A + {3'b000, d} - 7'd10;
    end
    return r;
  endfunction

endpackage

@@ rtl/i2a_in_if.sv @@
`timescale 1ns / 1ps

interface i2a_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

@@ rtl/i2a_out_if.sv @@
`timescale 1ns / 1ps

interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic [3:0] char_index;
  logic       last_char;

  modport source (output valid, output char_code, output char_index, output last_char,
                  input ready);
  modport sink   (input valid, input char_code, input char_index, input last_char,
                  output ready);
endinterface

@@ rtl/i2a_front.sv @@
`timescale 1ns / 1ps

module i2a_front
  import i2a_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  i2a_in_if.sink    in_ch,
  output logic      out_valid,
  input  logic      out_ready,
  output conv_t     out_data
);

  logic  valid;
  conv_t data;
  conv_t data_next;
  logic  neg;

  // unsigned negation also covers the most negative value
  always_comb begin
    neg                = (in_ch.command == CMD_DEC) && in_ch.value[WordBits-1];
    data_next.hex      = (in_ch.command == CMD_HEX);
    data_next.neg      = neg;
    data_next.bin      = neg ? (~in_ch.value + 32'd1) : in_ch.value;
    data_next.bcd      = '0;
  end

  assign in_ch.ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ch.ready) begin
      valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

@@ rtl/i2a_dabble_stage.sv @@
`timescale 1ns / 1ps

module i2a_dabble_stage
  import i2a_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  conv_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output conv_t out_data
);

  logic  valid;
  conv_t data;
  conv_t data_next;

  always_comb begin
    data_next = in_data;
    for (int s = 0; s < StepsPerStage; s++) begin
      data_next = dabble_step(data_next);
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

@@ rtl/i2a_serializer.sv @@
`timescale 1ns / 1ps

module i2a_serializer
  import i2a_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  conv_t     in_data,
  i2a_out_if.source out_ch
);

  logic                 busy;
  logic                 minus_pend;
  logic [3:0]           ptr;
  logic [IndexBits-1:0] idx;
  logic [3:0]           digs [DigitCount];

  logic                 ovalid;
  logic [CharBits-1:0]  ochar;
  logic [IndexBits-1:0] oidx;
  logic                 olast;

  logic [3:0]           top_digit;
  logic                 advance;
  logic                 finishing;
  logic                 load;
  logic [CharBits-1:0]  cur_char;
  logic                 cur_last;

  // highest nonzero digit; zero gives a single digit
  always_comb begin
    top_digit = '0;
    for (int i = 0; i < DigitCount; i++) begin
      if (in_data.bcd[4*i +: 4] != 4'd0) begin
        top_digit = 4'(i);
      end
    end
  end

  assign advance   = busy && (!ovalid || out_ch.ready);
  assign finishing = advance && !minus_pend && (ptr == 4'd0);
  assign in_ready  = !busy || finishing;
  assign load      = in_valid && in_ready;
  assign cur_char  = minus_pend ? CH_MINUS : digit_char(digs[ptr]);
  assign cur_last  = !minus_pend && (ptr == 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (advance) begin
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      minus_pend <= in_data.neg;
      ptr        <= top_digit;
      idx        <= '0;
      for (int i = 0; i < DigitCount; i++) begin
        digs[i] <= in_data.bcd[4*i +: 4];
      end
    end else if (advance) begin
      if (minus_pend) begin
        minus_pend <= 1'b0;
      end else if (ptr != 4'd0) begin
        ptr <= ptr - 4'd1;
      end
      idx <= idx + 4'd1;
    end
    if (advance) begin
      ochar <= cur_char;
      oidx  <= idx;
      olast <= cur_last;
    end
  end

  assign out_ch.valid      = ovalid;
  assign out_ch.char_code  = ochar;
  assign out_ch.char_index = oidx;
  assign out_ch.last_char  = olast;

endmodule

@@ rtl/integer_to_ascii_formatter.sv @@
`timescale 1ns / 1ps

// integer to ascii formatter
// in_ch takes one 32-bit value with a command: decimal prints it signed with a
// leading minus when negative, hex prints it unsigned in lower case with no
// leading zeros. out_ch gives the characters most significant first, one per
// transfer, with char_index counting from 0 and last_char on the final one.
// the conversion is a pipeline: an input register, eight double-dabble stages
// of four shift steps each, and a serializer with an output register.
// a value's first character passes the input register, the stage registers, the
// serializer's digit register and its output register. while out_ch accepts,
// the serializer sends one character per cycle; a value has 1 to 11 characters
// in decimal, 1 to 8 in hex. up to eleven values can be in flight; in_ch ready
// drops once they back up. when out_ch stalls, the output register holds its
// character and full stages behind it hold; nothing is lost or repeated.
// reset (synchronous, active high) empties the pipeline and the serializer.
module integer_to_ascii_formatter
  import i2a_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  i2a_in_if.sink    in_ch,
  i2a_out_if.source out_ch
);

  logic  stg_valid [StageCount+1];
  logic  stg_ready [StageCount+1];
  conv_t stg_data  [StageCount+1];

  i2a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  for (genvar g = 0; g < StageCount; g++) begin : g_stage
    i2a_dabble_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_data   (stg_data[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  i2a_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stg_valid[StageCount]),
    .in_ready (stg_ready[StageCount]),
    .in_data  (stg_data[StageCount]),
    .out_ch   (out_ch)
  );

  a_minus_leads: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.char_code == CH_MINUS
      |-> out_ch.char_index == 4'd0 && !out_ch.last_char)
    else $error("minus sign not at start of run");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.char_index <= 4'd10)
    else $error("character index out of range");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |->
      (out_ch.char_code >= CH_ZERO && out_ch.char_code <= CH_ZERO + 7'd9) ||
      (out_ch.char_code >= CH_LOWER_A && out_ch.char_code <= CH_LOWER_A + 7'd5) ||
      out_ch.char_code == CH_MINUS)
    else $error("character outside digit set");

  a_load_after_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && !out_ch.last_char |=> out_ch.valid)
    else $error("gap inside a character run");

endmodule
